/* hdl/dib_pkg.sv */
// Package for the dictionary index builder: payload structs, constants, FSM states
// and the FNV-1a byte step. No dependencies.
package dib_pkg;

    // Table sizes. The bucket count must stay a power of two so that the start
    // bucket is the low hash bits; the entry count fits the 12-bit index field.
    localparam int MaxEntries  = 4096;
    localparam int BucketCount = 8192;
    localparam logic [31:0] FnvBasis  = 32'h811c9dc5;
    localparam logic [31:0] FnvPrime  = 32'h01000193;
    localparam logic [1:0]  RegValueWidthMode = 2'd0;

    typedef struct packed {
        logic [63:0] value;
        logic        last_in_page;
    } in_item_t;

    typedef struct packed {
        logic [11:0] dict_index;
        logic        is_new;
        logic [63:0] value_out;
        logic        overflow;
        logic [12:0] entry_count;
        logic [3:0]  index_bit_width;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PROBE,
        ST_CHECK,
        ST_COMPARE,
        ST_OUT
    } dib_state_t;

    // One FNV-1a round: xor a byte then multiply by the prime.
    function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] x;
        x = h ^ {24'd0, b};
        return x * FnvPrime;
    endfunction

endpackage

/* hdl/dictionary_index_builder.sv */
// Dictionary index builder top level: FNV-1a hash, linear-probe bucket memory and
// value memory with a small sequencer. Depends on dib_pkg.
//
//  channel  | direction | ports
//  s_       | in        | s_valid, s_ready, s_data (in_item_t)
//  m_       | out       | m_valid, m_ready, m_data (out_item_t)
//  apb      | in/out    | psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// Each transaction hashes 4 or 8 bytes (one byte per cycle, one 32-bit multiply
// each), then does a bucket read and a check per probed bucket, plus a compare
// after a value memory read for every occupied bucket.
// After reset, and after a last_in_page transaction, a clearing pass writes every
// bucket empty, one per cycle, while s_ready stays low.
// The result waits in a pending register while the output register is full.
module dictionary_index_builder
    import dib_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int MAX_ENTRIES  = MaxEntries;
    localparam int BUCKET_COUNT = BucketCount;
    localparam int EW = $clog2(MAX_ENTRIES);
    localparam int BW = $clog2(BUCKET_COUNT);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    // Configuration register.
    logic mode_reg;

    // Memories. The bucket table holds stored index + 1, zero meaning empty.
    logic [CW-1:0] bucket_mem [BUCKET_COUNT];
    logic [63:0]   value_mem [MAX_ENTRIES];
    logic [CW-1:0] bucket_rd_reg;
    logic [63:0]   value_rd_reg;
    logic          bkt_we;
    logic [BW-1:0] bkt_waddr;
    logic [CW-1:0] bkt_wdata;
    logic [BW-1:0] bkt_raddr;
    logic          val_we;
    logic [EW-1:0] val_addr;

    // Control and datapath registers.
    dib_state_t    state_reg, state_next;
    logic [BW-1:0] sweep_reg, sweep_next;
    logic [CW-1:0] count_reg, count_next;
    logic [63:0]   value_reg, value_next;
    logic          last_reg, last_next;
    logic [31:0]   hash_reg, hash_next;
    logic [2:0]    byte_reg, byte_next;
    logic [BW-1:0] slot_reg, slot_next;
    logic [BW-1:0] probes_reg, probes_next;
    out_item_t     res_reg, res_next;
    logic          m_valid_reg, m_valid_next;
    out_item_t     m_data_reg, m_data_next;

    logic [CW-1:0] entry;
    logic [EW-1:0] entry_idx;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'(4 * RegValueWidthMode)) ? {31'd0, mode_reg} : 32'd0;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b1;
        end else if (psel && penable && pwrite && paddr == 2'(4 * RegValueWidthMode)) begin
            mode_reg <= pwdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (bkt_we) begin
            bucket_mem[bkt_waddr] <= bkt_wdata;
        end
        bucket_rd_reg <= bucket_mem[bkt_raddr];
    end

    always_ff @(posedge aclk) begin
        if (val_we) begin
            value_mem[val_addr] <= value_reg;
        end
        value_rd_reg <= value_mem[val_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            sweep_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sweep_reg   <= sweep_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        value_reg  <= value_next;
        last_reg   <= last_next;
        hash_reg   <= hash_next;
        byte_reg   <= byte_next;
        slot_reg   <= slot_next;
        probes_reg <= probes_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign s_ready = (state_reg == ST_IDLE);

    // Bit length of count-1, at least 1; zero when empty.
    function automatic logic [3:0] index_width(input logic [CW-1:0] n);
        logic [CW-1:0] m;
        logic [3:0] w;
        m = n - 1'b1;
        w = 4'd0;
        for (int i = 0; i < CW; i++) begin
            if (m[i]) w = 4'(i + 1);
        end
        if (n == '0) return 4'd0;
        return (w == 4'd0) ? 4'd1 : w;
    endfunction

    assign entry     = bucket_rd_reg;
    assign entry_idx = EW'(entry - 1'b1);

    always_comb begin
        state_next   = state_reg;
        sweep_next   = sweep_reg;
        count_next   = count_reg;
        value_next   = value_reg;
        last_next    = last_reg;
        hash_next    = hash_reg;
        byte_next    = byte_reg;
        slot_next    = slot_reg;
        probes_next  = probes_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        bkt_we       = 1'b0;
        bkt_waddr    = sweep_reg;
        bkt_wdata    = '0;
        bkt_raddr    = slot_reg;
        val_we       = 1'b0;
        val_addr     = entry_idx;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                bkt_we     = 1'b1;
                sweep_next = sweep_reg + 1'b1;
                count_next = '0;
                if (sweep_reg == BW'(BUCKET_COUNT - 1)) begin
                    sweep_next = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    value_next = mode_reg ? s_data.value : {32'd0, s_data.value[31:0]};
                    last_next  = s_data.last_in_page;
                    hash_next  = FnvBasis;
                    byte_next  = '0;
                    state_next = ST_HASH;
                end
            end
            ST_HASH: begin
                hash_next = fnv_step(hash_reg, value_reg[8*byte_reg +: 8]);
                byte_next = byte_reg + 1'b1;
                if (byte_reg == (mode_reg ? 3'd7 : 3'd3)) begin
                    // The bucket count is a power of two, so the low bits are the modulo.
                    slot_next   = hash_next[BW-1:0];
                    probes_next = '0;
                    state_next  = ST_PROBE;
                end
            end
            ST_PROBE: begin
                // Bucket read issued at slot_reg; data visible next cycle.
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (entry == '0) begin
                    // Empty bucket: the value is new, stored here unless the store is full.
                    res_next           = '0;
                    res_next.value_out = value_reg;
                    if (count_reg >= CW'(MAX_ENTRIES)) begin
                        res_next.overflow        = 1'b1;
                        res_next.entry_count     = count_reg;
                        res_next.index_bit_width = index_width(count_reg);
                    end else begin
                        val_we                   = 1'b1;
                        val_addr                 = EW'(count_reg);
                        bkt_we                   = 1'b1;
                        bkt_waddr                = slot_reg;
                        bkt_wdata                = count_reg + 1'b1;
                        count_next               = count_reg + 1'b1;
                        res_next.is_new          = 1'b1;
                        res_next.dict_index      = EW'(count_reg);
                        res_next.entry_count     = count_next;
                        res_next.index_bit_width = index_width(count_next);
                    end
                    state_next = ST_OUT;
                end else begin
                    // Occupied bucket: the value memory read of its entry runs this cycle.
                    state_next = ST_COMPARE;
                end
            end
            ST_COMPARE: begin
                if (value_rd_reg == value_reg) begin
                    res_next                 = '0;
                    res_next.dict_index      = entry_idx;
                    res_next.value_out       = value_reg;
                    res_next.entry_count     = count_reg;
                    res_next.index_bit_width = index_width(count_reg);
                    state_next               = ST_OUT;
                end else if (probes_reg == BW'(BUCKET_COUNT - 1)) begin
                    // Every bucket probed without a match or a free bucket.
                    res_next                 = '0;
                    res_next.overflow        = 1'b1;
                    res_next.value_out       = value_reg;
                    res_next.entry_count     = count_reg;
                    res_next.index_bit_width = index_width(count_reg);
                    state_next               = ST_OUT;
                end else begin
                    probes_next = probes_reg + 1'b1;
                    slot_next   = slot_reg + 1'b1;
                    state_next  = ST_PROBE;
                end
            end
            ST_OUT: begin
                // The pending result moves once the output register is free or being taken.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = last_reg ? ST_CLEAR : ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // Assertions.
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while busy");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_ENTRIES))
        else $error("entry count beyond capacity");
    a_new_not_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.is_new && m_data.overflow))
        else $error("result both new and overflow");
    a_clear_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> !s_ready)
        else $error("ready during clearing pass");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while waiting");

endmodule
